[hdl/sem_pkg.sv]
// Shared types, constants and helpers for the Sobel edge magnitude block.
package sem_pkg;

    // Frame size limits and register format
    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MIN_SIZE    = 3;
    localparam int CFG_W       = 13;
    localparam int POS_W       = 12;
    localparam int PIX_W       = 8;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);

    // Configuration register indexes
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Gradient widths: each weighted sum fits 10 bits, the difference 11 signed
    localparam int SUM_W  = PIX_W + 2;
    localparam int GRAD_W = SUM_W + 1;
    localparam int MAG_W  = SUM_W + 1;
    localparam int MAG_MAX = 255;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } t_pixel_in;

    typedef struct packed {
        logic [PIX_W-1:0] magnitude;
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic             frame_last;
    } t_edge_out;

    // One full 3x3 window with the centre position, index row*3 + col
    typedef struct packed {
        logic [8:0][PIX_W-1:0] pix;
        logic [POS_W-1:0]      out_row;
        logic [POS_W-1:0]      out_col;
        logic                  frame_last;
    } t_win_item;

    typedef struct packed {
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_q_status;

    // Clamp a size register into the range in use
    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                    input logic [CFG_W-1:0] maxv);
        logic [CFG_W-1:0] res;
        if (v < CFG_W'(MIN_SIZE)) begin
            res = CFG_W'(MIN_SIZE);
        end else if (v > maxv) begin
            res = maxv;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

[hdl/sobel_edge_magnitude.sv]
// Top level of the streaming 3x3 Sobel edge magnitude block.
//
//   channel   direction  handshake              payload
//   pixels    in         i_valid / o_stall      i_data  (t_pixel_in)
//   edges     out        o_valid / i_stall      o_data  (t_edge_out)
//   config    in         i_cfg_we               i_cfg_index, i_cfg_data
//
// Takes one pixel per clock while o_stall is low; both line stores are read
// once per pixel. A result passes the first stage, the window queue, the
// gradient stage and the output register after its last pixel transfer.
// Reset is synchronous and active low; the line stores need no clearing.
// Input stall rises when the window queue and the front stage hold four items.
module sobel_edge_magnitude (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  sem_pkg::t_pixel_in        i_data,
    output logic                      o_stall,
    output logic                      o_valid,
    output sem_pkg::t_edge_out        o_data,
    input  logic                      i_stall,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [sem_pkg::CFG_W-1:0] i_cfg_data
);

    logic [sem_pkg::CFG_W-1:0] r_image_width;
    logic [sem_pkg::CFG_W-1:0] r_image_height;

    logic                      push;
    logic                      pop;
    sem_pkg::t_win_item        push_data;
    sem_pkg::t_win_item        q_data;
    sem_pkg::t_q_status        q_status;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= sem_pkg::CFG_W'(sem_pkg::MAX_WIDTH);
            r_image_height <= sem_pkg::CFG_W'(sem_pkg::MAX_HEIGHT);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sem_pkg::REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                sem_pkg::REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sem_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_data         (i_data),
        .o_stall        (o_stall),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .i_q_status     (q_status),
        .o_push         (push),
        .o_push_data    (push_data)
    );

    sem_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (push_data),
        .i_pop    (pop),
        .o_data   (q_data),
        .o_status (q_status)
    );

    sem_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_q_data   (q_data),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .o_data     (o_data),
        .i_stall    (i_stall)
    );

    // Queue never takes a push it has no room for
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && !pop && (q_status.count == sem_pkg::QCNT_W'(sem_pkg::QUEUE_DEPTH))))
        else $error("window queue overflow");

    // Full queue always holds off the pixel input
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_status.count == sem_pkg::QCNT_W'(sem_pkg::QUEUE_DEPTH)) |-> o_stall)
        else $error("pixel input not stalled on full queue");

    // Results only ever name interior centres
    a_interior_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.out_row != '0) && (o_data.out_col != '0))
        else $error("result for a border pixel");

endmodule

[hdl/sem_ram.sv]
// Generic single write port, single read port RAM with registered read.
module sem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, and read the old contents on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/sem_front.sv]
// Front end: position tracking, line stores, 3x3 window and result classification.
module sem_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  sem_pkg::t_pixel_in        i_data,
    output logic                      o_stall,
    input  logic [sem_pkg::CFG_W-1:0] i_image_width,
    input  logic [sem_pkg::CFG_W-1:0] i_image_height,
    input  sem_pkg::t_q_status        i_q_status,
    output logic                      o_push,
    output sem_pkg::t_win_item        o_push_data
);

    logic [sem_pkg::CFG_W-1:0] w_use;
    logic [sem_pkg::CFG_W-1:0] h_use;
    logic                      accept;
    logic [sem_pkg::POS_W-1:0] cur_col;
    logic [sem_pkg::POS_W-1:0] cur_row;

    logic [sem_pkg::POS_W-1:0] r_col;
    logic [sem_pkg::POS_W-1:0] r_row;
    logic [sem_pkg::POS_W-1:0] n_col;
    logic [sem_pkg::POS_W-1:0] n_row;

    // First stage: line store data arrives here
    logic                      r_f1_valid;
    logic [sem_pkg::PIX_W-1:0] r_f1_pix;
    logic [sem_pkg::POS_W-1:0] r_f1_col;
    logic [sem_pkg::POS_W-1:0] r_f1_row;
    logic                      r_f1_hit;
    logic [sem_pkg::PIX_W-1:0] r_fwd_top;
    logic [sem_pkg::PIX_W-1:0] r_fwd_mid;

    logic [sem_pkg::PIX_W-1:0] upper_rd;
    logic [sem_pkg::PIX_W-1:0] middle_rd;
    logic [sem_pkg::PIX_W-1:0] f1_top;
    logic [sem_pkg::PIX_W-1:0] f1_mid;

    logic [8:0][sem_pkg::PIX_W-1:0] r_win;
    logic [8:0][sem_pkg::PIX_W-1:0] n_win;

    logic [sem_pkg::QCNT_W:0]  in_flight;

    assign w_use = sem_pkg::clamp_size(i_image_width, sem_pkg::CFG_W'(sem_pkg::MAX_WIDTH));
    assign h_use = sem_pkg::clamp_size(i_image_height, sem_pkg::CFG_W'(sem_pkg::MAX_HEIGHT));

    // Hold off input while the queue cannot take everything in flight
    assign in_flight = {1'b0, i_q_status.count} + (sem_pkg::QCNT_W + 1)'(r_f1_valid);
    assign o_stall   = in_flight >= (sem_pkg::QCNT_W + 1)'(sem_pkg::QUEUE_DEPTH);
    assign accept    = i_valid && !o_stall;

    // Position of the incoming pixel, frame start forces the origin
    assign cur_col = i_data.frame_start ? '0 : r_col;
    assign cur_row = i_data.frame_start ? '0 : r_row;

    // Advance the raster position
    always_comb begin
        n_col = cur_col + sem_pkg::POS_W'(1);
        n_row = cur_row;
        if ({1'b0, cur_col} + sem_pkg::CFG_W'(1) >= w_use) begin
            n_col = '0;
            if ({1'b0, cur_row} + sem_pkg::CFG_W'(1) >= h_use) begin
                n_row = '0;
            end else begin
                n_row = cur_row + sem_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_f1_valid <= 1'b0;
        end else begin
            r_f1_valid <= accept;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // Capture the pixel and note a same-column write in flight for bypass
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f1_pix  <= i_data.pixel;
            r_f1_col  <= cur_col;
            r_f1_row  <= cur_row;
            r_f1_hit  <= r_f1_valid && (r_f1_col == cur_col);
            r_fwd_top <= f1_mid;
            r_fwd_mid <= r_f1_pix;
        end
    end

    // Line stores: read at acceptance, write back in the first stage
    sem_ram #(
        .WIDTH (sem_pkg::PIX_W),
        .DEPTH (sem_pkg::MAX_WIDTH)
    ) u_upper (
        .i_clk   (i_clk),
        .i_we    (r_f1_valid),
        .i_waddr (r_f1_col[sem_pkg::ADDR_W-1:0]),
        .i_wdata (f1_mid),
        .i_re    (accept),
        .i_raddr (cur_col[sem_pkg::ADDR_W-1:0]),
        .o_rdata (upper_rd)
    );

    sem_ram #(
        .WIDTH (sem_pkg::PIX_W),
        .DEPTH (sem_pkg::MAX_WIDTH)
    ) u_middle (
        .i_clk   (i_clk),
        .i_we    (r_f1_valid),
        .i_waddr (r_f1_col[sem_pkg::ADDR_W-1:0]),
        .i_wdata (r_f1_pix),
        .i_re    (accept),
        .i_raddr (cur_col[sem_pkg::ADDR_W-1:0]),
        .o_rdata (middle_rd)
    );

    assign f1_top = r_f1_hit ? r_fwd_top : upper_rd;
    assign f1_mid = r_f1_hit ? r_fwd_mid : middle_rd;

    // Shift the window left and load the new column
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_win[k*3 + 0] = r_win[k*3 + 1];
            n_win[k*3 + 1] = r_win[k*3 + 2];
        end
        n_win[2] = f1_top;
        n_win[5] = f1_mid;
        n_win[8] = r_f1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_f1_valid) begin
            r_win <= n_win;
        end
    end

    // Only interior centres produce a result
    assign o_push = r_f1_valid && (r_f1_row >= sem_pkg::POS_W'(2))
                    && (r_f1_col >= sem_pkg::POS_W'(2));
    assign o_push_data.pix        = n_win;
    assign o_push_data.out_row    = r_f1_row - sem_pkg::POS_W'(1);
    assign o_push_data.out_col    = r_f1_col - sem_pkg::POS_W'(1);
    assign o_push_data.frame_last = ({1'b0, r_f1_row} == h_use - sem_pkg::CFG_W'(1))
                                 && ({1'b0, r_f1_col} == w_use - sem_pkg::CFG_W'(1));

endmodule

[hdl/sem_queue.sv]
// Short queue of full windows between front and back.
module sem_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sem_pkg::t_win_item i_data,
    input  logic               i_pop,
    output sem_pkg::t_win_item o_data,
    output sem_pkg::t_q_status o_status
);

    sem_pkg::t_win_item         r_mem [sem_pkg::QUEUE_DEPTH];
    logic [sem_pkg::QPTR_W-1:0] r_wptr;
    logic [sem_pkg::QPTR_W-1:0] r_rptr;
    logic [sem_pkg::QCNT_W-1:0] r_count;

    // Store on push
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + sem_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + sem_pkg::QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + sem_pkg::QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - sem_pkg::QCNT_W'(1);
            end
        end
    end

    assign o_data         = r_mem[r_rptr];
    assign o_status.count = r_count;
    assign o_status.empty = (r_count == '0);

endmodule

[hdl/sem_back.sv]
// Back end: Sobel gradients, L1 magnitude with saturation, output register.
module sem_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sem_pkg::t_q_status i_q_status,
    input  sem_pkg::t_win_item i_q_data,
    output logic               o_pop,
    output logic               o_valid,
    output sem_pkg::t_edge_out o_data,
    input  logic               i_stall
);

    logic out_ready;
    logic b1_ready;

    logic [sem_pkg::SUM_W-1:0]         sum_r;
    logic [sem_pkg::SUM_W-1:0]         sum_l;
    logic [sem_pkg::SUM_W-1:0]         sum_b;
    logic [sem_pkg::SUM_W-1:0]         sum_t;

    logic                              r_b1_valid;
    logic signed [sem_pkg::GRAD_W-1:0] r_gx;
    logic signed [sem_pkg::GRAD_W-1:0] r_gy;
    logic [sem_pkg::POS_W-1:0]         r_b1_row;
    logic [sem_pkg::POS_W-1:0]         r_b1_col;
    logic                              r_b1_last;

    logic [sem_pkg::SUM_W-1:0]         abs_gx;
    logic [sem_pkg::SUM_W-1:0]         abs_gy;
    logic [sem_pkg::MAG_W-1:0]         mag;
    logic [sem_pkg::PIX_W-1:0]         mag_sat;

    logic                              r_out_valid;
    sem_pkg::t_edge_out                r_out;

    assign out_ready = !r_out_valid || !i_stall;
    assign b1_ready  = !r_b1_valid || out_ready;
    assign o_pop     = !i_q_status.empty && b1_ready;

    // Weighted column and row sums of the window
    assign sum_r = sem_pkg::SUM_W'(i_q_data.pix[2]) + {1'b0, i_q_data.pix[5], 1'b0}
                 + sem_pkg::SUM_W'(i_q_data.pix[8]);
    assign sum_l = sem_pkg::SUM_W'(i_q_data.pix[0]) + {1'b0, i_q_data.pix[3], 1'b0}
                 + sem_pkg::SUM_W'(i_q_data.pix[6]);
    assign sum_b = sem_pkg::SUM_W'(i_q_data.pix[6]) + {1'b0, i_q_data.pix[7], 1'b0}
                 + sem_pkg::SUM_W'(i_q_data.pix[8]);
    assign sum_t = sem_pkg::SUM_W'(i_q_data.pix[0]) + {1'b0, i_q_data.pix[1], 1'b0}
                 + sem_pkg::SUM_W'(i_q_data.pix[2]);

    // Gradient stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
        end else if (b1_ready) begin
            r_b1_valid <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_gx      <= $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
            r_gy      <= $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
            r_b1_row  <= i_q_data.out_row;
            r_b1_col  <= i_q_data.out_col;
            r_b1_last <= i_q_data.frame_last;
        end
    end

    // Absolute values, sum and clip to a byte
    assign abs_gx  = r_gx[sem_pkg::GRAD_W-1] ? sem_pkg::SUM_W'(-r_gx) : sem_pkg::SUM_W'(r_gx);
    assign abs_gy  = r_gy[sem_pkg::GRAD_W-1] ? sem_pkg::SUM_W'(-r_gy) : sem_pkg::SUM_W'(r_gy);
    assign mag     = sem_pkg::MAG_W'(abs_gx) + sem_pkg::MAG_W'(abs_gy);
    assign mag_sat = (mag > sem_pkg::MAG_W'(sem_pkg::MAG_MAX))
                   ? sem_pkg::PIX_W'(sem_pkg::MAG_MAX) : mag[sem_pkg::PIX_W-1:0];

    // Output register, held while the consumer stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_b1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_b1_valid) begin
            r_out.magnitude  <= mag_sat;
            r_out.out_row    <= r_b1_row;
            r_out.out_col    <= r_b1_col;
            r_out.frame_last <= r_b1_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

[tb/tb.sv]
// Self-checking testbench for sobel_edge_magnitude: pixel frames checked against a window predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sem_pkg::*;

    typedef enum int {TEX_NOISE, TEX_BINARY, TEX_RAMP, TEX_STRIPES} tex_e;

    localparam int RANDOM_ITEMS  = 750;
    localparam int SETTLE_CYCLES = 12;
    localparam int RESET_PIXELS  = 64;
    localparam int FILL_WIDTH    = 64;
    localparam int TALL_ROWS     = 90;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 pix_valid  = 1'b0;
    t_pixel_in            pix_data   = '0;
    logic                 pix_stall;
    logic                 edge_valid;
    t_edge_out            edge_data;
    logic                 edge_stall = 1'b0;
    logic                 cfg_we     = 1'b0;
    logic                 cfg_index  = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0]     cfg_data   = '0;

    // Pixels waiting for transfer and edge results waiting to come out
    t_pixel_in            pixels_to_send [$];
    t_edge_out            pending_edges [$];

    // Predictor state: line stores, window, position and size registers
    logic [PIX_W-1:0]     upper_line [MAX_WIDTH];
    logic [PIX_W-1:0]     middle_line [MAX_WIDTH];
    logic [PIX_W-1:0]     win [9];
    logic [POS_W-1:0]     col_pos    = '0;
    logic [POS_W-1:0]     row_pos    = '0;
    logic [CFG_W-1:0]     width_reg  = CFG_W'(MAX_WIDTH);
    logic [CFG_W-1:0]     height_reg = CFG_W'(MAX_HEIGHT);

    int                   sender_idle_pct   = 0;
    int                   receiver_idle_pct = 0;
    int                   sender_gap        = 0;
    int                   receiver_gap      = 0;
    int                   fault_count       = 0;

    sobel_edge_magnitude dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (pix_valid),
        .i_data      (pix_data),
        .o_stall     (pix_stall),
        .o_valid     (edge_valid),
        .o_data      (edge_data),
        .i_stall     (edge_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int size_in_use(input logic [CFG_W-1:0] v, input int lim);
        if (v < MIN_SIZE) begin
            return MIN_SIZE;
        end
        if (v > lim) begin
            return lim;
        end
        return int'(v);
    endfunction

    // Advance the window by one pixel and queue the edge result it yields
    task automatic predict_edges(input t_pixel_in px);
        int        w, h, c, r, gx, gy, mag;
        t_edge_out e;
        w = size_in_use(width_reg, MAX_WIDTH);
        h = size_in_use(height_reg, MAX_HEIGHT);
        if (px.frame_start) begin
            col_pos = '0;
            row_pos = '0;
        end
        c = col_pos;
        r = row_pos;
        for (int k = 0; k < 3; k++) begin
            win[k*3]   = win[k*3+1];
            win[k*3+1] = win[k*3+2];
        end
        win[2] = upper_line[c];
        win[5] = middle_line[c];
        win[8] = px.pixel;
        upper_line[c]  = middle_line[c];
        middle_line[c] = px.pixel;
        if (r >= 2 && c >= 2) begin
            gx = int'(win[2]) + 2 * int'(win[5]) + int'(win[8])
               - int'(win[0]) - 2 * int'(win[3]) - int'(win[6]);
            gy = int'(win[6]) + 2 * int'(win[7]) + int'(win[8])
               - int'(win[0]) - 2 * int'(win[1]) - int'(win[2]);
            mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
            e.magnitude  = (mag > MAG_MAX) ? PIX_W'(MAG_MAX) : PIX_W'(mag);
            e.out_row    = POS_W'(r - 1);
            e.out_col    = POS_W'(c - 1);
            e.frame_last = (r == h - 1 && c == w - 1);
            pending_edges.push_back(e);
        end
        if (c + 1 >= w) begin
            col_pos = '0;
            row_pos = (r + 1 >= h) ? '0 : POS_W'(r + 1);
        end else begin
            col_pos = POS_W'(c + 1);
        end
    endtask

    task automatic note_mismatch(input string field, input int want, input int got);
        fault_count++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    endtask

    // Compare one result with the oldest expectation
    task automatic check_edge(input t_edge_out got);
        t_edge_out want;
        if (pending_edges.size() == 0) begin
            fault_count++;
            $display("%0t: result mismatch: expected none, actual row %0d col %0d mag %0d",
                     $time, got.out_row, got.out_col, got.magnitude);
        end else begin
            want = pending_edges.pop_front();
            if (got.magnitude !== want.magnitude) begin
                note_mismatch("magnitude", want.magnitude, got.magnitude);
            end
            if (got.out_row !== want.out_row) begin
                note_mismatch("out_row", want.out_row, got.out_row);
            end
            if (got.out_col !== want.out_col) begin
                note_mismatch("out_col", want.out_col, got.out_col);
            end
            if (got.frame_last !== want.frame_last) begin
                note_mismatch("frame_last", want.frame_last, got.frame_last);
            end
        end
    endtask

    // Pixel driver: predict on each transfer, then hold, idle or load the next pixel
    always @(posedge clk) begin
        if (!rst_n) begin
            pix_valid <= 1'b0;
        end else begin
            if (pix_valid && !pix_stall) begin
                predict_edges(pix_data);
            end
            if (!pix_valid || !pix_stall) begin
                if (sender_gap > 0) begin
                    sender_gap--;
                    pix_valid <= 1'b0;
                end else if (pixels_to_send.size() > 0 &&
                             $urandom_range(99) < sender_idle_pct) begin
                    sender_gap = $urandom_range(14);
                    pix_valid <= 1'b0;
                end else if (pixels_to_send.size() > 0) begin
                    pix_data  <= pixels_to_send.pop_front();
                    pix_valid <= 1'b1;
                end else begin
                    pix_valid <= 1'b0;
                end
            end
        end
    end

    // Edge monitor: check each transfer, stall in random bursts, drop a burst once idling ends
    always @(posedge clk) begin
        if (!rst_n) begin
            edge_stall <= 1'b0;
        end else begin
            if (edge_valid && !edge_stall) begin
                check_edge(edge_data);
            end
            if (receiver_gap > 0 && receiver_idle_pct > 0) begin
                receiver_gap--;
                edge_stall <= 1'b1;
            end else if ($urandom_range(99) < receiver_idle_pct) begin
                receiver_gap = $urandom_range(14);
                edge_stall <= 1'b1;
            end else begin
                edge_stall <= 1'b0;
            end
        end
    end

    task automatic push_pixel(input logic [PIX_W-1:0] p, input logic fs);
        t_pixel_in px;
        px.pixel       = p;
        px.frame_start = fs;
        pixels_to_send.push_back(px);
    endtask

    function automatic logic [PIX_W-1:0] texture(input tex_e tex, input int x, input int y);
        case (tex)
            TEX_BINARY: begin
                return $urandom_range(1) ? PIX_W'(MAG_MAX) : '0;
            end
            TEX_RAMP: begin
                return PIX_W'(x * 9 + y * 5 + $urandom_range(3));
            end
            TEX_STRIPES: begin
                return (y % 2) ? PIX_W'(200 + $urandom_range(55)) : PIX_W'($urandom_range(40));
            end
            default: begin
                return PIX_W'($urandom);
            end
        endcase
    endfunction

    // Queue the first count pixels of a w x h frame
    task automatic queue_frame(input int w, input int h, input tex_e tex, input bit flagged,
                               input int count);
        for (int i = 0; i < count; i++) begin
            push_pixel(texture(tex, i % w, i / w), flagged && i == 0);
        end
    endtask

    // Widths stay inside the columns already filled; only heights may go above the limit
    function automatic logic [CFG_W-1:0] pick_size(input int common_max, input bit allow_large);
        int roll;
        roll = $urandom_range(19);
        if (roll == 0) begin
            return CFG_W'($urandom_range(2));
        end
        if (roll == 1 && allow_large) begin
            return CFG_W'(MAX_WIDTH + $urandom_range(4095));
        end
        if (roll < 4) begin
            return CFG_W'($urandom_range(40, common_max + 1));
        end
        return CFG_W'($urandom_range(common_max, 3));
    endfunction

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_IMAGE_WIDTH) begin
            width_reg = val;
        end else begin
            height_reg = val;
        end
    endtask

    // Wait until every pixel is sent and every result is in, then let the pipe empty
    task automatic settle_idle();
        while (pixels_to_send.size() != 0 || pix_valid || pending_edges.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        int   random_items;
        int   budget;
        int   take;
        int   roll;
        int   w;
        int   h;
        for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        for (int i = 0; i < 9; i++) begin
            win[i] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset sizes: part of a first row, which gives no results
        sender_idle_pct   = 10;
        receiver_idle_pct = 10;
        queue_frame(MAX_WIDTH, MAX_HEIGHT, TEX_NOISE, 1'b1, RESET_PIXELS);
        settle_idle();

        // One short wide frame fills both line stores over every column used later
        write_reg(REG_IMAGE_WIDTH, CFG_W'(FILL_WIDTH));
        write_reg(REG_IMAGE_HEIGHT, CFG_W'(MIN_SIZE));
        queue_frame(FILL_WIDTH, MIN_SIZE, TEX_NOISE, 1'b1, MIN_SIZE * FILL_WIDTH);
        settle_idle();

        // Smallest frame: saturating edge, flat frame by wrap, restart mid-frame
        sender_idle_pct   = 20;
        receiver_idle_pct = 20;
        write_reg(REG_IMAGE_WIDTH, CFG_W'(MIN_SIZE));
        write_reg(REG_IMAGE_HEIGHT, CFG_W'(MIN_SIZE));
        for (int i = 0; i < 9; i++) begin
            push_pixel(PIX_W'((i % 3) * 255 / 2), i == 0);
        end
        for (int i = 0; i < 9; i++) begin
            push_pixel(PIX_W'(MAG_MAX), 1'b0);
        end
        push_pixel(PIX_W'(77), 1'b0);
        for (int i = 0; i < 9; i++) begin
            push_pixel(PIX_W'(9 - i), i == 0);
        end
        settle_idle();

        // Upper rows of the tallest frame of narrowest rows, both registers out of range
        sender_idle_pct   = 10;
        receiver_idle_pct = 10;
        write_reg(REG_IMAGE_WIDTH, '0);
        write_reg(REG_IMAGE_HEIGHT, '1);
        queue_frame(MIN_SIZE, MAX_HEIGHT, TEX_NOISE, 1'b1, MIN_SIZE * TALL_ROWS);
        settle_idle();

        // Random phases of frames; each phase may end mid-frame before a size change
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (random_items > RANDOM_ITEMS * 5 / 6) begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end else begin
                sender_idle_pct   = ($urandom_range(3) == 0) ? 0 : $urandom_range(50, 2);
                receiver_idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(50, 2);
            end
            if ($urandom_range(3) != 0) begin
                write_reg(REG_IMAGE_WIDTH, pick_size(12, 1'b0));
            end
            if ($urandom_range(3) != 0) begin
                write_reg(REG_IMAGE_HEIGHT, pick_size(8, 1'b1));
            end
            w = size_in_use(width_reg, MAX_WIDTH);
            h = size_in_use(height_reg, MAX_HEIGHT);
            budget = $urandom_range(160, 40);
            while (budget > 0) begin
                roll = $urandom_range(99);
                take = w * h;
                if (roll >= 80 && roll < 90) begin
                    take = $urandom_range(w * h - 1, 1);
                end
                if (take > budget) begin
                    take = budget;
                end
                queue_frame(w, h, tex_e'($urandom_range(3)), roll < 90, take);
                budget -= take;
                random_items += take;
            end
            settle_idle();
        end

        if (fault_count == 0) begin
            $display("** sobel_edge_magnitude: PASSED **");
        end else begin
            $display("** sobel_edge_magnitude: FAILED **");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #8_000_000;
        $display("** sobel_edge_magnitude: FAILED **");
        $finish;
    end

endmodule
